@@ rtl/imhpq_pkg.sv @@
// shared types, constants and compare functions for the indexed min-heap
package imhpq_pkg;

    localparam int NODES  = 1024;
    localparam int NODE_W = 10;
    localparam int POS_W  = 11;
    localparam int COST_W = 32;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_UPDATE  = 2'd1;
    localparam logic [1:0] MODE_EXTRACT = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_HELD     = 3'd3;
    localparam logic [2:0] ST_NOT_HELD = 3'd4;

    localparam logic [POS_W-1:0] POS_FULL = POS_W'(NODES);

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              net;
        logic              dom;
        logic [COST_W-1:0] cost;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        logic [POS_W-1:0]  data;
    } t_pos_wr;

    typedef struct packed {
        logic              we;
        logic [NODE_W-1:0] addr;
        t_entry            data;
    } t_heap_wr;

    // heap position 1..NODES to memory address
    function automatic logic [NODE_W-1:0] slot_addr(input logic [POS_W-1:0] pos);
        logic [POS_W-1:0] a;
        a = pos - POS_W'(1);
        return a[NODE_W-1:0];
    endfunction

    // moving entry climbs above its parent
    function automatic logic up_swap(input t_entry m, input t_entry p);
        if (m.cost < p.cost) return 1'b1;
        if (m.cost == p.cost) return m.net && p.dom && !m.dom;
        return 1'b0;
    endfunction

    // right child preferred over left
    function automatic logic pick_right(input t_entry l, input t_entry r);
        return (l.cost > r.cost) || ((l.cost == r.cost) && r.net);
    endfunction

    // moving entry sinks below the chosen child
    function automatic logic down_swap(input t_entry m, input t_entry c);
        if (m.cost < c.cost) return 1'b0;
        if (m.cost == c.cost) return c.net && !(m.net && c.dom);
        return 1'b1;
    endfunction

endpackage

@@ rtl/imhpq_heap_ram.sv @@
// heap slot memory: one write port, two registered read ports
module imhpq_heap_ram
    import imhpq_pkg::*;
(
    input  logic              i_clk,
    input  t_heap_wr          i_wr,
    input  logic [NODE_W-1:0] i_raddr_a,
    input  logic [NODE_W-1:0] i_raddr_b,
    output t_entry            o_rdata_a,
    output t_entry            o_rdata_b
);
    t_entry mem [NODES];
    t_entry r_rd_a;
    t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_a <= mem[i_raddr_a];
        r_rd_b <= mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;
endmodule

@@ rtl/imhpq_pos_ram.sv @@
// node position memory: one write port, one registered read port
module imhpq_pos_ram
    import imhpq_pkg::*;
(
    input  logic              i_clk,
    input  t_pos_wr           i_wr,
    input  logic [NODE_W-1:0] i_raddr,
    output logic [POS_W-1:0]  o_rdata
);
    logic [POS_W-1:0] mem [NODES];
    logic [POS_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        r_rd <= mem[i_raddr];
    end

    assign o_rdata = r_rd;
endmodule

@@ rtl/indexed_min_heap_priority_queue.sv @@
// top level: sequencer for the indexed min-heap over heap and position memories
//
// Input channel (i_valid / o_stall) takes one operation word: insert, update
// cost of a held node, extract minimum or no-op. Output channel (o_valid / i_stall)
// returns one result word per operation: node, cost, status, occupancy.
// One operation is in work at a time; the next word is accepted only after the
// previous one has returned its result. Each heap level moved takes one memory
// read step and one compare and write back step. The result word appears in
// the same cycle as the next word can be accepted.
// The moving entry is held in a register; each level writes only the
// displaced neighbor, and the final slot is written once at the end.
// After reset the position memory is cleared, one entry a cycle, over all 1024
// entries; o_stall stays high during that pass.
// A result waiting in the output register while i_stall is high holds the
// next operation at its result step; o_stall stays high and no new word is accepted meanwhile.
module indexed_min_heap_priority_queue
    import imhpq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_mode,
    input  logic [NODE_W-1:0] i_node_id,
    input  logic [COST_W-1:0] i_key_cost,
    input  logic              i_is_net,
    input  logic              i_is_domain,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [NODE_W-1:0] o_out_node,
    output logic [COST_W-1:0] o_out_cost,
    output logic [2:0]        o_status,
    output logic [POS_W-1:0]  o_occupancy
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CHK, S_UPD, S_EXT, S_UP_RD, S_UP_CMP,
        S_DN_RD, S_DN_CMP, S_FIN, S_RES
    } t_state;

    t_state            r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [NODE_W-1:0] r_node, n_node;
    logic [COST_W-1:0] r_key, n_key;
    logic              r_net, n_net;
    logic              r_dom, n_dom;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic [POS_W-1:0]  r_hole, n_hole;
    t_entry            r_mov, n_mov;
    logic [NODE_W-1:0] r_res_node, n_res_node;
    logic [COST_W-1:0] r_res_cost, n_res_cost;
    logic [2:0]        r_res_stat, n_res_stat;
    logic [NODE_W-1:0] r_clr, n_clr;
    logic              r_ov, n_ov;
    logic [NODE_W-1:0] r_onode, n_onode;
    logic [COST_W-1:0] r_ocost, n_ocost;
    logic [2:0]        r_ostat, n_ostat;
    logic [POS_W-1:0]  r_oocc, n_oocc;

    t_heap_wr          heap_wr;
    t_pos_wr           pos_wr;
    logic [NODE_W-1:0] heap_ra, heap_rb, pos_ra;
    t_entry            heap_da, heap_db;
    logic [POS_W-1:0]  pos_d;
    logic [POS_W-1:0]  child;
    logic              use_right;
    t_entry            cand;
    logic              out_free;

    imhpq_heap_ram u_heap (
        .i_clk     (i_clk),
        .i_wr      (heap_wr),
        .i_raddr_a (heap_ra),
        .i_raddr_b (heap_rb),
        .o_rdata_a (heap_da),
        .o_rdata_b (heap_db)
    );

    imhpq_pos_ram u_pos (
        .i_clk   (i_clk),
        .i_wr    (pos_wr),
        .i_raddr (pos_ra),
        .o_rdata (pos_d)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ov || !i_stall;

    // left child position of the hole and which child wins
    assign child     = {r_hole[POS_W-2:0], 1'b0};
    assign use_right = (child < r_cnt) && pick_right(heap_da, heap_db);
    assign cand      = use_right ? heap_db : heap_da;

    always_comb begin
        n_state    = r_state;
        n_mode     = r_mode;
        n_node     = r_node;
        n_key      = r_key;
        n_net      = r_net;
        n_dom      = r_dom;
        n_cnt      = r_cnt;
        n_hole     = r_hole;
        n_mov      = r_mov;
        n_res_node = r_res_node;
        n_res_cost = r_res_cost;
        n_res_stat = r_res_stat;
        n_clr      = r_clr;
        n_ov       = r_ov && i_stall;
        n_onode    = r_onode;
        n_ocost    = r_ocost;
        n_ostat    = r_ostat;
        n_oocc     = r_oocc;
        heap_wr    = '0;
        pos_wr     = '0;
        heap_ra    = slot_addr(r_hole);
        heap_rb    = slot_addr(r_cnt);
        pos_ra     = r_node;

        unique case (r_state)
            S_CLEAR: begin
                pos_wr.we   = 1'b1;
                pos_wr.addr = r_clr;
                n_clr       = r_clr + NODE_W'(1);
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_mode     = i_mode;
                    n_node     = i_node_id;
                    n_key      = i_key_cost;
                    n_net      = i_is_net;
                    n_dom      = i_is_domain;
                    n_res_node = i_node_id;
                    n_res_cost = '0;
                    n_res_stat = ST_OK;
                    pos_ra     = i_node_id;
                    heap_ra    = slot_addr(POS_W'(1));
                    unique case (i_mode)
                        MODE_INSERT: begin
                            if (r_cnt >= POS_FULL) begin
                                n_res_stat = ST_FULL;
                                n_state    = S_RES;
                            end else begin
                                n_state = S_CHK;
                            end
                        end
                        MODE_UPDATE: n_state = S_CHK;
                        MODE_EXTRACT: begin
                            if (r_cnt == '0) begin
                                n_res_stat = ST_EMPTY;
                                n_res_node = '0;
                                n_state    = S_RES;
                            end else begin
                                n_state = S_EXT;
                            end
                        end
                        default: begin
                            n_res_node = '0;
                            n_state    = S_RES;
                        end
                    endcase
                end
            end
            S_CHK: begin
                n_mov = '{node: r_node, net: r_net, dom: r_dom, cost: r_key};
                if (r_mode == MODE_INSERT) begin
                    if (pos_d != '0) begin
                        n_res_stat = ST_HELD;
                        n_state    = S_RES;
                    end else begin
                        n_cnt      = r_cnt + POS_W'(1);
                        n_hole     = r_cnt + POS_W'(1);
                        n_res_cost = r_key;
                        n_state    = S_UP_RD;
                    end
                end else if (pos_d == '0) begin
                    n_res_stat = ST_NOT_HELD;
                    n_state    = S_RES;
                end else begin
                    n_hole  = pos_d;
                    heap_ra = slot_addr(pos_d);
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                // kind stays as set at insert
                n_mov.net  = heap_da.net;
                n_mov.dom  = heap_da.dom;
                n_res_cost = r_key;
                if (r_key > heap_da.cost) n_state = S_DN_RD;
                else if (r_key < heap_da.cost) n_state = S_UP_RD;
                else n_state = S_RES;
            end
            S_EXT: begin
                n_res_node  = heap_da.node;
                n_res_cost  = heap_da.cost;
                pos_wr.we   = 1'b1;
                pos_wr.addr = heap_da.node;
                pos_wr.data = '0;
                n_cnt       = r_cnt - POS_W'(1);
                n_mov       = heap_db;
                n_hole      = POS_W'(1);
                n_state     = (r_cnt == POS_W'(1)) ? S_RES : S_DN_RD;
            end
            S_UP_RD: begin
                heap_ra = slot_addr(r_hole >> 1);
                n_state = (r_hole == POS_W'(1)) ? S_FIN : S_UP_CMP;
            end
            S_UP_CMP: begin
                if (up_swap(r_mov, heap_da)) begin
                    heap_wr.we   = 1'b1;
                    heap_wr.addr = slot_addr(r_hole);
                    heap_wr.data = heap_da;
                    pos_wr.we    = 1'b1;
                    pos_wr.addr  = heap_da.node;
                    pos_wr.data  = r_hole;
                    n_hole       = r_hole >> 1;
                    n_state      = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DN_RD: begin
                heap_ra = slot_addr(child);
                heap_rb = child[NODE_W-1:0];
                n_state = (r_hole <= (r_cnt >> 1)) ? S_DN_CMP : S_FIN;
            end
            S_DN_CMP: begin
                if (down_swap(r_mov, cand)) begin
                    heap_wr.we   = 1'b1;
                    heap_wr.addr = slot_addr(r_hole);
                    heap_wr.data = cand;
                    pos_wr.we    = 1'b1;
                    pos_wr.addr  = cand.node;
                    pos_wr.data  = r_hole;
                    n_hole       = child + POS_W'(use_right);
                    n_state      = S_DN_RD;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                heap_wr.we   = 1'b1;
                heap_wr.addr = slot_addr(r_hole);
                heap_wr.data = r_mov;
                pos_wr.we    = 1'b1;
                pos_wr.addr  = r_mov.node;
                pos_wr.data  = r_hole;
                n_state      = S_RES;
            end
            S_RES: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_onode = r_res_node;
                    n_ocost = r_res_cost;
                    n_ostat = r_res_stat;
                    n_oocc  = r_cnt;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
        r_mode     <= n_mode;
        r_node     <= n_node;
        r_key      <= n_key;
        r_net      <= n_net;
        r_dom      <= n_dom;
        r_hole     <= n_hole;
        r_mov      <= n_mov;
        r_res_node <= n_res_node;
        r_res_cost <= n_res_cost;
        r_res_stat <= n_res_stat;
        r_onode    <= n_onode;
        r_ocost    <= n_ocost;
        r_ostat    <= n_ostat;
        r_oocc     <= n_oocc;
    end

    assign o_valid     = r_ov;
    assign o_out_node  = r_onode;
    assign o_out_cost  = r_ocost;
    assign o_status    = r_ostat;
    assign o_occupancy = r_oocc;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= POS_FULL) else $error("entry count above capacity");

    a_up_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_CMP) |-> (r_hole > POS_W'(1)))
        else $error("sift up compare at root");

    a_dn_hole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_CMP) |-> (child <= r_cnt))
        else $error("sift down past last entry");
`endif
endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the indexed min-heap priority queue
`timescale 1ns / 1ps

module tb_top;
    import imhpq_pkg::*;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [COST_W-1:0] cost;
        logic [2:0]        status;
        logic [POS_W-1:0]  occ;
    } t_result;

    class heap_scoreboard;
        int                heap_at[NODES+1];
        int                pos_of[NODES];
        logic [COST_W-1:0] cost_of[NODES];
        logic [1:0]        kind_of[NODES];
        int                count;
        int                errors;
        t_result           pending[$];

        function void clear();
            foreach (pos_of[i]) pos_of[i] = 0;
            count = 0;
            errors = 0;
            pending.delete();
        endfunction

        function void swap_at(int a, int b);
            int t;
            t = heap_at[a];
            heap_at[a] = heap_at[b];
            heap_at[b] = t;
            pos_of[heap_at[a]] = a;
            pos_of[heap_at[b]] = b;
        endfunction

        function void climb(int n);
            int c;
            int pn;
            c = pos_of[n];
            while (c > 1) begin
                pn = heap_at[c/2];
                if (cost_of[n] > cost_of[pn]) return;
                if (cost_of[n] == cost_of[pn] &&
                    (!kind_of[n][0] || !kind_of[pn][1] || kind_of[n][1])) return;
                swap_at(c, c/2);
                c = c/2;
            end
        endfunction

        function void sink(int n);
            int p;
            int c;
            int cn;
            int rn;
            p = pos_of[n];
            while (p <= count/2) begin
                c = p*2;
                cn = heap_at[c];
                if (c < count) begin
                    rn = heap_at[c+1];
                    if (cost_of[cn] > cost_of[rn] ||
                        (cost_of[cn] == cost_of[rn] && kind_of[rn][0])) begin
                        cn = rn;
                        c++;
                    end
                end
                if (cost_of[n] < cost_of[cn]) break;
                if (cost_of[n] == cost_of[cn]) begin
                    if (!kind_of[cn][0]) break;
                    if (kind_of[n][0] && kind_of[cn][1]) break;
                end
                swap_at(p, c);
                p = c;
            end
        endfunction

        function void note_word(logic [1:0] mode, logic [NODE_W-1:0] id,
                                logic [COST_W-1:0] key, logic net, logic dom);
            t_result r;
            int top;
            int last;
            logic [COST_W-1:0] old;
            r.node = id;
            r.cost = '0;
            r.status = ST_OK;
            if (mode == MODE_INSERT) begin
                if (count >= NODES) r.status = ST_FULL;
                else if (pos_of[id] != 0) r.status = ST_HELD;
                else begin
                    count++;
                    heap_at[count] = id;
                    pos_of[id] = count;
                    cost_of[id] = key;
                    kind_of[id] = {dom, net};
                    climb(id);
                    r.cost = key;
                end
            end else if (mode == MODE_UPDATE) begin
                if (pos_of[id] == 0) r.status = ST_NOT_HELD;
                else begin
                    old = cost_of[id];
                    cost_of[id] = key;
                    if (key > old) sink(id);
                    else if (key < old) climb(id);
                    r.cost = key;
                end
            end else if (mode == MODE_EXTRACT) begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                    r.node = '0;
                end else begin
                    top = heap_at[1];
                    last = heap_at[count];
                    r.node = NODE_W'(top);
                    r.cost = cost_of[top];
                    pos_of[top] = 0;
                    count--;
                    if (count != 0) begin
                        heap_at[1] = last;
                        pos_of[last] = 1;
                        sink(last);
                    end
                end
            end else begin
                r.node = '0;
            end
            r.occ = POS_W'(count);
            pending.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: node %0d", got.node);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.node !== e.node) begin
                $error("out_node expected %0d got %0d", e.node, got.node);
                errors++;
            end
            if (got.cost !== e.cost) begin
                $error("out_cost expected %0d got %0d", e.cost, got.cost);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status expected %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.occ !== e.occ) begin
                $error("occupancy expected %0d got %0d", e.occ, got.occ);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [1:0]        i_mode = MODE_INSERT;
    logic [NODE_W-1:0] i_node_id = '0;
    logic [COST_W-1:0] i_key_cost = '0;
    logic              i_is_net = 1'b0;
    logic              i_is_domain = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [NODE_W-1:0] o_out_node;
    logic [COST_W-1:0] o_out_cost;
    logic [2:0]        o_status;
    logic [POS_W-1:0]  o_occupancy;

    heap_scoreboard sb;
    int  send_idle_pct = 28;
    int  recv_idle_pct = 49;
    bit  hold_recv = 1'b0;
    int  quiet_cycles = 0;
    int  ids[$];

    localparam int QUIET_LIMIT = 20000;

    always #6 i_clk = ~i_clk;

    indexed_min_heap_priority_queue uut (.*);

    // receiver stall and result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_word({o_out_node, o_out_cost, o_status, o_occupancy});
        i_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] mode, logic [NODE_W-1:0] id,
                             logic [COST_W-1:0] key, logic net, logic dom);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_node_id <= id;
        i_key_cost <= key;
        i_is_net <= net;
        i_is_domain <= dom;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_word(mode, id, key, net, dom);
    endtask

    task automatic go_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        go_idle();
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(3))
            0: return COST_W'($urandom_range(7));
            1: return COST_W'({$urandom, $urandom} >> $urandom_range(31));
            2: return COST_W'('1) - COST_W'($urandom_range(3));
            default: return COST_W'($urandom);
        endcase
    endfunction

    function automatic logic [NODE_W-1:0] pick_id(int pool);
        if (pool > 0 && $urandom_range(3) != 0) return NODE_W'($urandom_range(pool - 1));
        return NODE_W'($urandom);
    endfunction

    task automatic random_phase(int n, int pool);
        int k;
        logic [1:0] m;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: m = MODE_INSERT;
                4, 5, 6: m = MODE_UPDATE;
                7, 8: m = MODE_EXTRACT;
                default: m = MODE_NOP;
            endcase
            send_word(m, pick_id(pool), pick_cost(), 1'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int k;
        sb = new();
        sb.clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty, errors, ties, extremes
        send_word(MODE_EXTRACT, 10'd5, 32'd9, 1'b0, 1'b0);
        send_word(MODE_UPDATE, 10'd3, 32'd1, 1'b0, 1'b0);
        send_word(MODE_NOP, 10'd7, 32'd7, 1'b1, 1'b1);
        send_word(MODE_INSERT, 10'd0, 32'hFFFFFFFF, 1'b0, 1'b0);
        send_word(MODE_INSERT, 10'd1023, 32'd0, 1'b1, 1'b1);
        send_word(MODE_INSERT, 10'd0, 32'd4, 1'b0, 1'b0);
        send_word(MODE_INSERT, 10'd10, 32'd50, 1'b0, 1'b1);
        send_word(MODE_INSERT, 10'd11, 32'd50, 1'b1, 1'b0);
        send_word(MODE_INSERT, 10'd12, 32'd50, 1'b0, 1'b0);
        send_word(MODE_INSERT, 10'd13, 32'd50, 1'b1, 1'b1);
        send_word(MODE_UPDATE, 10'd1023, 32'd60, 1'b0, 1'b0);
        send_word(MODE_UPDATE, 10'd0, 32'd1, 1'b1, 1'b1);
        send_word(MODE_UPDATE, 10'd0, 32'd1, 1'b0, 1'b0);
        send_word(MODE_UPDATE, 10'd999, 32'd1, 1'b0, 1'b0);
        for (k = 0; k < 8; k++) send_word(MODE_EXTRACT, '0, '0, 1'b0, 1'b0);
        drain();

        // fill to full while the receiver holds off for a long stretch
        fork
            begin
                hold_recv = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_recv = 1'b0;
            end
        join_none
        for (k = 0; k < NODES; k++) ids.push_back(k);
        ids.shuffle();
        foreach (ids[i])
            send_word(MODE_INSERT, NODE_W'(ids[i]), COST_W'($urandom_range(15)),
                      1'($urandom), 1'($urandom));
        send_word(MODE_INSERT, 10'd5, 32'd1, 1'b0, 1'b0);
        send_word(MODE_EXTRACT, '0, '0, 1'b0, 1'b0);
        send_word(MODE_INSERT, 10'd77, 32'd3, 1'b1, 1'b0);
        drain();
        send_idle_pct = 0;
        for (k = 0; k < 500; k++) send_word(MODE_EXTRACT, '0, '0, 1'b0, 1'b0);
        drain();

        // random traffic on small id pools so updates and ties hit held nodes
        send_idle_pct = 28;
        recv_idle_pct = 49;
        random_phase(150, 16);
        drain();
        send_idle_pct = 49;
        recv_idle_pct = 28;
        random_phase(150, 64);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(100, 256);

        drain();
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
